@@ rtl/mlc_pkg.sv @@
`default_nettype none
package mlc_pkg;

  localparam int FIRST_WAYS_DEF      = 4;
  localparam int SECOND_WAYS_DEF     = 8;
  localparam int THIRD_WAYS_DEF      = 8;
  localparam int FIRST_MAX_SETS_DEF  = 64;
  localparam int SECOND_MAX_SETS_DEF = 256;
  localparam int THIRD_MAX_SETS_DEF  = 1024;

  // dividend covers a 32 bit tag times an 11 bit set count plus the set
  localparam int DIVD_W = 44;
  // divisor covers bytes per block and every set count register
  localparam int DIVR_W = 13;
  localparam int TAG_W  = 32;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_LEVELS      = 3'd0;
  localparam logic [IDX_W-1:0] REG_WRITE_BACK  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BLOCK_BYTES = 3'd2;
  localparam logic [IDX_W-1:0] REG_SETS_FIRST  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SETS_SECOND = 3'd4;
  localparam logic [IDX_W-1:0] REG_SETS_THIRD  = 3'd5;

  typedef struct packed {
    logic [31:0] address;
    logic        opcode;
  } mlc_in_t;

  typedef struct packed {
    logic first_hit;
    logic second_accessed;
    logic second_hit;
    logic third_accessed;
    logic third_hit;
    logic first_dirty_evict;
    logic second_dirty_evict;
    logic third_dirty_evict;
  } mlc_out_t;

  typedef enum logic [1:0] {
    LOP_CLEAR,
    LOP_ACCESS,
    LOP_MARK
  } lvl_op_t;

  typedef struct packed {
    logic    rd;
    logic    wr;
    lvl_op_t op;
  } lvl_cmd_t;

  typedef struct packed {
    logic             hit;
    logic             evict_dirty;
    logic [TAG_W-1:0] victim_tag;
  } lvl_stat_t;

endpackage
`default_nettype wire

@@ rtl/multilevel_lru_cache_tag_model.sv @@
`default_nettype none
// channel  | signals                     | beat
// in       | in_valid, in_ready, in_data  | one access: address, opcode
// out      | out_valid, out_ready, out_data | one result: hit, lookup, evict flags
// cfg      | cfg_we, cfg_index, cfg_data  | one register write, no handshake
// one access at a time; a serial divider does every division
// steps: accept and block division, then per level looked up a set division and lookup,
// plus a division and a mark in the level below per dirty eviction passed to it
// after reset a clearing pass over the sets of the largest level runs before in_ready
// a finished result waits in the output register; the next access may start meanwhile
module multilevel_lru_cache_tag_model
  import mlc_pkg::*;
#(
  parameter int FIRST_WAYS      = FIRST_WAYS_DEF,
  parameter int SECOND_WAYS     = SECOND_WAYS_DEF,
  parameter int THIRD_WAYS      = THIRD_WAYS_DEF,
  parameter int FIRST_MAX_SETS  = FIRST_MAX_SETS_DEF,
  parameter int SECOND_MAX_SETS = SECOND_MAX_SETS_DEF,
  parameter int THIRD_MAX_SETS  = THIRD_MAX_SETS_DEF
)(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mlc_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mlc_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SW1 = (FIRST_MAX_SETS > 1) ? $clog2(FIRST_MAX_SETS) : 1;
  localparam int SW2 = (SECOND_MAX_SETS > 1) ? $clog2(SECOND_MAX_SETS) : 1;
  localparam int SW3 = (THIRD_MAX_SETS > 1) ? $clog2(THIRD_MAX_SETS) : 1;
  localparam int CLR_A = (FIRST_MAX_SETS > SECOND_MAX_SETS) ? FIRST_MAX_SETS : SECOND_MAX_SETS;
  localparam int CLR_N = (CLR_A > THIRD_MAX_SETS) ? CLR_A : THIRD_MAX_SETS;
  localparam int CW    = $clog2(CLR_N + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BLK_GO, S_BLK_WAIT, S_SET_GO, S_SET_WAIT, S_RD, S_EVAL,
    S_MUL, S_MDIV_GO, S_MDIV_WAIT, S_MRD, S_MWR, S_NEXT, S_DONE
  } state_t;

  state_t state;

  logic [1:0]        levels_in_use;
  logic              write_back;
  logic [12:0]       bytes_per_block;
  logic [6:0]        sets_first;
  logic [8:0]        sets_second;
  logic [10:0]       sets_third;

  logic [CW-1:0]     clr_cnt;
  logic [1:0]        lvl;
  logic [31:0]       addr;
  logic              is_write;
  logic [DIVD_W-1:0] blk;
  logic [DIVD_W-1:0] key;
  logic [DIVR_W-1:0] set_q;
  logic [DIVD_W-1:0] mblk;
  logic [2:0]        hit_f;
  logic [2:0]        acc_f;
  logic [2:0]        ev_f;
  logic              cur_hit;

  logic [1:0]        lv_n;
  logic              more;
  logic [DIVR_W-1:0] eff_sets [3];
  logic [DIVR_W-1:0] bpb;
  logic [1:0]        lvl_nx;
  logic              load_out;

  logic              div_start;
  logic              div_done;
  logic [DIVD_W-1:0] div_a;
  logic [DIVR_W-1:0] div_b;
  logic [DIVD_W-1:0] div_q;
  logic [DIVR_W-1:0] div_r;

  lvl_cmd_t          cmd  [3];
  lvl_stat_t         stat [3];
  logic [CW-1:0]     clr_lim [3];

  function automatic logic [DIVR_W-1:0] eff(input logic [DIVR_W-1:0] s, input int mx);
    logic [DIVR_W-1:0] r;
    r = (s == '0) ? DIVR_W'(1) : s;
    if (32'(r) > 32'(mx)) r = DIVR_W'(mx);
    return r;
  endfunction

  assign lv_n   = (levels_in_use == 2'd0) ? 2'd1 : levels_in_use;
  assign more   = ({1'b0, lvl} + 3'd1) < {1'b0, lv_n};
  assign lvl_nx = lvl + 2'd1;
  assign bpb    = (bytes_per_block == '0) ? DIVR_W'(1) : bytes_per_block;
  assign eff_sets[0] = eff(DIVR_W'(sets_first), FIRST_MAX_SETS);
  assign eff_sets[1] = eff(DIVR_W'(sets_second), SECOND_MAX_SETS);
  assign eff_sets[2] = eff(DIVR_W'(sets_third), THIRD_MAX_SETS);
  assign clr_lim[0]  = CW'(FIRST_MAX_SETS);
  assign clr_lim[1]  = CW'(SECOND_MAX_SETS);
  assign clr_lim[2]  = CW'(THIRD_MAX_SETS);

  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_BLK_GO) || (state == S_SET_GO) || (state == S_MDIV_GO);
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    div_a = blk;
    div_b = eff_sets[lvl];
    unique case (state)
      S_BLK_GO:  begin div_a = DIVD_W'(addr); div_b = bpb; end
      S_MDIV_GO: begin div_a = mblk; div_b = eff_sets[lvl_nx]; end
      default:   begin div_a = blk; div_b = eff_sets[lvl]; end
    endcase
  end

  mlc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmd[i] = '{rd: 1'b0, wr: 1'b0, op: LOP_CLEAR};
      if (state == S_CLEAR) begin
        cmd[i].wr = clr_cnt < clr_lim[i];
      end else if (state == S_RD && lvl == 2'(i)) begin
        cmd[i].rd = 1'b1;
      end else if (state == S_EVAL && lvl == 2'(i)) begin
        cmd[i] = '{rd: 1'b0, wr: 1'b1, op: LOP_ACCESS};
      end else if (state == S_MRD && lvl_nx == 2'(i)) begin
        cmd[i].rd = 1'b1;
      end else if (state == S_MWR && lvl_nx == 2'(i)) begin
        cmd[i] = '{rd: 1'b0, wr: 1'b1, op: LOP_MARK};
      end
    end
  end

  mlc_level #(.WAYS(FIRST_WAYS), .MAX_SETS(FIRST_MAX_SETS)) u_first (
    .clk        (clk),
    .cmd        (cmd[0]),
    .set        ((state == S_CLEAR) ? SW1'(clr_cnt) : SW1'(set_q)),
    .key        (key),
    .is_write   (is_write),
    .write_back (write_back),
    .stat       (stat[0])
  );

  mlc_level #(.WAYS(SECOND_WAYS), .MAX_SETS(SECOND_MAX_SETS)) u_second (
    .clk        (clk),
    .cmd        (cmd[1]),
    .set        ((state == S_CLEAR) ? SW2'(clr_cnt) : SW2'(set_q)),
    .key        (key),
    .is_write   (is_write),
    .write_back (write_back),
    .stat       (stat[1])
  );

  mlc_level #(.WAYS(THIRD_WAYS), .MAX_SETS(THIRD_MAX_SETS)) u_third (
    .clk        (clk),
    .cmd        (cmd[2]),
    .set        ((state == S_CLEAR) ? SW3'(clr_cnt) : SW3'(set_q)),
    .key        (key),
    .is_write   (is_write),
    .write_back (write_back),
    .stat       (stat[2])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use   <= 2'd1;
      write_back      <= 1'b1;
      bytes_per_block <= 13'd16;
      sets_first      <= 7'd64;
      sets_second     <= 9'd256;
      sets_third      <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVELS:      levels_in_use   <= cfg_data[1:0];
        REG_WRITE_BACK:  write_back      <= cfg_data[0];
        REG_BLOCK_BYTES: bytes_per_block <= cfg_data[12:0];
        REG_SETS_FIRST:  sets_first      <= cfg_data[6:0];
        REG_SETS_SECOND: sets_second     <= cfg_data[8:0];
        REG_SETS_THIRD:  sets_third      <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      lvl       <= '0;
    end else begin
      if (out_valid && out_ready && !load_out) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            addr     <= in_data.address;
            is_write <= in_data.opcode;
            lvl      <= '0;
            hit_f    <= '0;
            acc_f    <= 3'b001;
            ev_f     <= '0;
            state    <= S_BLK_GO;
          end
        end
        S_BLK_GO: state <= S_BLK_WAIT;
        S_BLK_WAIT: begin
          if (div_done) begin
            blk   <= div_q;
            state <= S_SET_GO;
          end
        end
        S_SET_GO: state <= S_SET_WAIT;
        S_SET_WAIT: begin
          if (div_done) begin
            key   <= div_q;
            set_q <= div_r;
            state <= S_RD;
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          cur_hit    <= stat[lvl].hit;
          hit_f[lvl] <= stat[lvl].hit;
          ev_f[lvl]  <= stat[lvl].evict_dirty;
          mblk       <= {{(DIVD_W - TAG_W){1'b0}}, stat[lvl].victim_tag}
                        * {{(DIVD_W - DIVR_W){1'b0}}, eff_sets[lvl]};
          state      <= (stat[lvl].evict_dirty && more) ? S_MUL : S_NEXT;
        end
        S_MUL: begin
          mblk  <= mblk + DIVD_W'(set_q);
          state <= S_MDIV_GO;
        end
        S_MDIV_GO: state <= S_MDIV_WAIT;
        S_MDIV_WAIT: begin
          if (div_done) begin
            key   <= div_q;
            set_q <= div_r;
            state <= S_MRD;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: state <= S_NEXT;
        S_NEXT: begin
          if (cur_hit || !more) begin
            state <= S_DONE;
          end else begin
            lvl           <= lvl_nx;
            acc_f[lvl_nx] <= 1'b1;
            state         <= S_SET_GO;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_valid                   <= 1'b1;
            out_data.first_hit          <= hit_f[0];
            out_data.second_accessed    <= acc_f[1];
            out_data.second_hit         <= hit_f[1];
            out_data.third_accessed     <= acc_f[2];
            out_data.third_hit          <= hit_f[2];
            out_data.first_dirty_evict  <= ev_f[0];
            out_data.second_dirty_evict <= ev_f[1];
            out_data.third_dirty_evict  <= ev_f[2];
            state                       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_BLK_WAIT || state == S_SET_WAIT || state == S_MDIV_WAIT))
    else $error("divider finished outside a wait state");
  a_lookup_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.third_accessed |-> out_data.second_accessed
      && !out_data.second_hit && !out_data.first_hit)
    else $error("third level looked up after a hit above");
  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> more && $past(stat[lvl].evict_dirty))
    else $error("next level mark without a dirty eviction");
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> !out_valid)
    else $error("result during clearing pass");
`endif

endmodule
`default_nettype wire

@@ rtl/mlc_div.sv @@
`default_nettype none
module mlc_div
  import mlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quot,
  output logic [DIVR_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIVR_W-1:0] dvs;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              take;

  assign trial = {rem, quot[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quot <= {quot[DIVD_W-2:0], take};
        rem  <= take ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/mlc_level.sv @@
`default_nettype none
module mlc_level
  import mlc_pkg::*;
#(
  parameter int WAYS     = FIRST_WAYS_DEF,
  parameter int MAX_SETS = FIRST_MAX_SETS_DEF,
  localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
)(
  input  logic              clk,
  input  lvl_cmd_t          cmd,
  input  logic [SW-1:0]     set,
  input  logic [DIVD_W-1:0] key,
  input  logic              is_write,
  input  logic              write_back,
  output lvl_stat_t         stat
);

  typedef logic [WAYS-1:0][WB-1:0] order_t;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    order_t                     lru;
  } row_t;

  row_t mem [MAX_SETS];
  row_t row_q;
  row_t wdata;

  logic [WAYS-1:0] match;
  logic            hit;
  logic [WB-1:0]   hit_way;
  logic [WB-1:0]   victim;

  function automatic order_t recent(input order_t o, input logic [WB-1:0] w);
    int     k;
    order_t n;
    k = WAYS - 1;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (o[i] == w) k = i;
    end
    for (int i = 0; i < WAYS - 1; i++) begin
      n[i] = (i < k) ? o[i] : o[i+1];
    end
    n[WAYS-1] = w;
    return n;
  endfunction

  always_comb begin
    hit_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = row_q.valid[i] && ({(DIVD_W - TAG_W)'(0), row_q.tag[i]} == key);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) hit_way = WB'(i);
    end
    hit    = |match;
    victim = (int'(row_q.lru[0]) >= WAYS) ? '0 : row_q.lru[0];
  end

  assign stat.hit         = hit;
  assign stat.evict_dirty = !hit && write_back && row_q.dirty[victim];
  assign stat.victim_tag  = row_q.tag[victim];

  always_comb begin
    wdata = row_q;
    unique case (cmd.op)
      LOP_CLEAR: begin
        wdata = '0;
        for (int i = 0; i < WAYS; i++) wdata.lru[i] = WB'(i);
      end
      LOP_ACCESS: begin
        if (hit) begin
          wdata.lru = recent(row_q.lru, hit_way);
          if (is_write) wdata.dirty[hit_way] = 1'b1;
        end else begin
          if (write_back) wdata.dirty[victim] = 1'b0;
          wdata.tag[victim]   = key[TAG_W-1:0];
          wdata.valid[victim] = 1'b1;
          wdata.lru           = recent(row_q.lru, victim);
        end
      end
      LOP_MARK: begin
        if (hit) wdata.dirty[hit_way] = 1'b1;
      end
      default: wdata = row_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[set] <= wdata;
    if (cmd.rd) row_q <= mem[set];
  end

endmodule
`default_nettype wire

@@ bench/multilevel_lru_cache_tag_model_tb.sv @@
`timescale 1ns / 1ps
module multilevel_lru_cache_tag_model_tb;
  import mlc_pkg::*;

  localparam int SETTLE = 700;
  localparam int WDOG_LIMIT = 40000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  mlc_in_t in_data;
  mlc_out_t out_data;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  multilevel_lru_cache_tag_model DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the tag arrays
  int unsigned lvl_ways[3] = '{4, 8, 8};
  int unsigned lvl_max_sets[3] = '{64, 256, 1024};
  logic [31:0] shadow_tag[3][8192];
  bit shadow_valid[3][8192];
  bit shadow_dirty[3][8192];
  int unsigned shadow_order[3][8192];

  logic [1:0] cfg_levels;
  logic cfg_wback;
  logic [12:0] cfg_bpb;
  logic [6:0] cfg_s1;
  logic [8:0] cfg_s2;
  logic [10:0] cfg_s3;

  mlc_out_t pending_results[$];
  int errors, accesses, results_seen, l1_hits, dirty_evicts;
  bit calm;
  int wdog;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sets_of(int l);
    int unsigned s;
    s = (l == 0) ? cfg_s1 : (l == 1) ? cfg_s2 : cfg_s3;
    if (s == 0) s = 1;
    if (s > lvl_max_sets[l]) s = lvl_max_sets[l];
    return s;
  endfunction

  function automatic void make_mru(int l, int unsigned base, int unsigned way);
    int unsigned k, i;
    k = lvl_ways[l] - 1;
    for (i = 0; i < lvl_ways[l]; i++)
      if (shadow_order[l][base + i] == way) begin
        k = i;
        break;
      end
    for (i = k; i + 1 < lvl_ways[l]; i++)
      shadow_order[l][base + i] = shadow_order[l][base + i + 1];
    shadow_order[l][base + lvl_ways[l] - 1] = way;
  endfunction

  function automatic bit find_tag(int l, int unsigned base, longint unsigned tg,
                                  output int unsigned way);
    int unsigned i;
    way = 0;
    for (i = 0; i < lvl_ways[l]; i++)
      if (shadow_valid[l][base + i] && longint'(shadow_tag[l][base + i]) == tg) begin
        way = i;
        return 1;
      end
    return 0;
  endfunction

  function automatic void mark_below(int l, longint unsigned blk);
    int unsigned s, set, way;
    s = sets_of(l);
    set = blk % s;
    if (find_tag(l, set * lvl_ways[l], blk / s, way))
      shadow_dirty[l][set * lvl_ways[l] + way] = 1;
  endfunction

  function automatic bit probe_level(int l, longint unsigned blk, bit wr, int unsigned nlv,
                                     output bit ev);
    int unsigned s, set, base, way;
    longint unsigned tg;
    s = sets_of(l);
    set = blk % s;
    tg = blk / s;
    base = set * lvl_ways[l];
    ev = 0;
    if (find_tag(l, base, tg, way)) begin
      make_mru(l, base, way);
      if (wr) shadow_dirty[l][base + way] = 1;
      return 1;
    end
    way = shadow_order[l][base];
    if (way >= lvl_ways[l]) way = 0;
    if (cfg_wback && shadow_dirty[l][base + way]) begin
      ev = 1;
      shadow_dirty[l][base + way] = 0;
      if (l + 1 < nlv)
        mark_below(l + 1, longint'(shadow_tag[l][base + way]) * s + set);
    end
    shadow_tag[l][base + way] = tg[31:0];
    shadow_valid[l][base + way] = 1;
    make_mru(l, base, way);
    return 0;
  endfunction

  function automatic mlc_out_t predict_access(logic [31:0] addr, bit wr);
    mlc_out_t r;
    int unsigned bpb, nlv;
    longint unsigned blk;
    bit h, e;
    r = '0;
    bpb = (cfg_bpb == 0) ? 1 : cfg_bpb;
    nlv = (cfg_levels == 0) ? 1 : cfg_levels;
    blk = longint'(addr) / bpb;
    r.first_hit = probe_level(0, blk, wr, nlv, e);
    r.first_dirty_evict = e;
    if (!r.first_hit && nlv > 1) begin
      r.second_accessed = 1;
      r.second_hit = probe_level(1, blk, wr, nlv, e);
      r.second_dirty_evict = e;
      if (!r.second_hit && nlv > 2) begin
        r.third_accessed = 1;
        r.third_hit = probe_level(2, blk, wr, nlv, e);
        r.third_dirty_evict = e;
      end
    end
    return r;
  endfunction

  task automatic send_access(logic [31:0] addr, bit wr);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{address: addr, opcode: wr};
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_access(addr, wr));
    accesses++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [1:0] nlv, logic wb, logic [12:0] bpb,
                            logic [6:0] s1, logic [8:0] s2, logic [10:0] s3);
    logic [CFG_W-1:0] vals[6];
    logic [IDX_W-1:0] idx[6];
    int i;
    vals = '{nlv, wb, bpb, s1, s2, s3};
    idx = '{REG_LEVELS, REG_WRITE_BACK, REG_BLOCK_BYTES, REG_SETS_FIRST,
            REG_SETS_SECOND, REG_SETS_THIRD};
    settle();
    for (i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_levels = nlv;
    cfg_wback = wb;
    cfg_bpb = bpb;
    cfg_s1 = s1;
    cfg_s2 = s2;
    cfg_s3 = s3;
  endtask

  task automatic test_reset_defaults();
    send_access(32'h0, 1'b0);
    send_access(32'h0, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'hFFFF_FFF0, 1'b0);
  endtask

  task automatic test_geometry_extremes();
    // zero levels, zero block size and zero set counts act as one
    write_regs(2'd0, 1'b1, 13'd0, 7'd0, 9'd0, 11'd0);
    send_access(32'h1234_5678, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b0);
    // set counts above the maximum saturate
    write_regs(2'd3, 1'b1, 13'd4096, 7'd127, 9'd511, 11'd2047);
    send_access(32'hA5A5_A5A5, 1'b0);
    send_access(32'h5A5A_5A5A, 1'b1);
  endtask

  task automatic test_dirty_chain();
    int i;
    write_regs(2'd3, 1'b1, 13'd1, 7'd1, 9'd1, 11'd1);
    send_access(32'd100, 1'b1);
    send_access(32'd100, 1'b1);
    for (i = 1; i <= 5; i++) send_access(32'd100 + i, 1'b0);
  endtask

  task automatic test_write_through();
    int i;
    write_regs(2'd2, 1'b0, 13'd1, 7'd1, 9'd1, 11'd1);
    send_access(32'd7, 1'b1);
    send_access(32'd7, 1'b1);
    for (i = 1; i <= 4; i++) send_access(32'd7 + i, 1'b0);
  endtask

  // mostly a small pool of hot blocks so hits and dirty evictions chain up
  task automatic random_phase(int n);
    logic [31:0] hot[$];
    logic [31:0] addr;
    int unsigned bpb, k, npool;
    int i;
    bpb = (cfg_bpb == 0) ? 1 : cfg_bpb;
    npool = $urandom_range(4, 40);
    for (i = 0; i < npool; i++) hot.push_back($urandom / bpb);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        addr = $urandom;
      end else begin
        k = $urandom_range(0, npool - 1);
        addr = hot[k] * bpb + $urandom_range(0, bpb - 1);
      end
      send_access(addr, $urandom_range(0, 1));
    end
  endtask

  task automatic test_random();
    write_regs(2'd3, 1'b1, 13'd1, 7'd1, 9'd1, 11'd1);
    random_phase(100);
    write_regs(2'd3, 1'b1, 13'd4096, 7'd2, 9'd3, 11'd5);
    random_phase(100);
    write_regs(2'd2, 1'b0, 13'd16, 7'd64, 9'd256, 11'd1024);
    random_phase(100);
    // geometry change keeps contents
    write_regs(2'd3, 1'b1, 13'd8, 7'd3, 9'd7, 11'd13);
    random_phase(100);
    write_regs(2'd1, 1'b1, 13'd64, 7'd4, 9'd1, 11'd1);
    random_phase(100);
    write_regs(2'd3, 1'b1, 13'd3, 7'd5, 9'd2, 11'd3);
    calm = 1;
    random_phase(100);
  endtask

  // output side stalls
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(1, 6) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_flag(string name, logic e, logic g);
    if (g !== e) begin
      $display("%0t mismatch %s: expected %b actual %b", $time, name, e, g);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    mlc_out_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_flag("first_hit", e.first_hit, out_data.first_hit);
        check_flag("second_accessed", e.second_accessed, out_data.second_accessed);
        check_flag("second_hit", e.second_hit, out_data.second_hit);
        check_flag("third_accessed", e.third_accessed, out_data.third_accessed);
        check_flag("third_hit", e.third_hit, out_data.third_hit);
        check_flag("first_dirty_evict", e.first_dirty_evict, out_data.first_dirty_evict);
        check_flag("second_dirty_evict", e.second_dirty_evict, out_data.second_dirty_evict);
        check_flag("third_dirty_evict", e.third_dirty_evict, out_data.third_dirty_evict);
        l1_hits += e.first_hit;
        dirty_evicts += e.first_dirty_evict + e.second_dirty_evict + e.third_dirty_evict;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("%0t watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int l, i;
    for (l = 0; l < 3; l++)
      for (i = 0; i < 8192; i++) begin
        shadow_tag[l][i] = '0;
        shadow_valid[l][i] = 0;
        shadow_dirty[l][i] = 0;
        shadow_order[l][i] = i % lvl_ways[l];
      end
    cfg_levels = 2'd1;
    cfg_wback = 1'b1;
    cfg_bpb = 13'd16;
    cfg_s1 = 7'd64;
    cfg_s2 = 9'd256;
    cfg_s3 = 11'd1024;
    errors = 0;
    accesses = 0;
    results_seen = 0;
    l1_hits = 0;
    dirty_evicts = 0;
    calm = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_geometry_extremes();
    test_dirty_chain();
    test_write_through();
    test_random();
    settle();
    $display("covered %0d accesses over 1 to 3 levels, write back and write through",
             accesses);
    $display("%0d results checked, %0d first level hits, %0d dirty evictions",
             results_seen, l1_hits, dirty_evicts);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
